FILE: hw/rtl/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants of the round-trip probe tracker.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // event codes on the input channel
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_ISSUE    = 3'd1,
        OP_PACKET   = 3'd2,
        OP_RESPONSE = 3'd3,
        OP_TIMEOUT  = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_MEASURED  = 3'd0,
        ST_UNMATCHED = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_ISSUED    = 3'd4,
        ST_STARTED   = 3'd5,
        ST_STAMP     = 3'd6,
        ST_FINISHED  = 3'd7
    } status_t;

    // id seed offset, one less than half the id space
    localparam logic [15:0] ID_SEED_OFFSET = 16'h7fff;
    // probe count after reset (minus one)
    localparam logic [31:0] COUNT_RESET    = 32'hffff_ffff;
    // mean deviation after reset, microseconds
    localparam logic [31:0] DEV_RESET      = 32'd3000000;

    // control stage result handed to the statistics and output stage
    typedef struct packed {
        status_t     status;
        logic [15:0] probe_id;
        logic [31:0] rtt;
        logic        meas;
        logic [31:0] probe_count;
        logic [31:0] drop_count;
        logic        done;
    } ctrl_res_t;

endpackage

FILE: hw/rtl/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// rpt_ctrl
// Probe control state: id, outstanding flag, send stamp, counters, finish.
// ----------------------------------------------------------------------------
module rpt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_limit,
    input  logic                 fire,
    input  logic [2:0]           operation,
    input  logic [15:0]          ip_id,
    input  logic [31:0]          stamp_us,
    output rpt_pkg::ctrl_res_t   res
);

    logic [15:0] probe_limit_reg;
    logic        outstanding_reg, outstanding_next;
    logic [15:0] current_id_reg, current_id_next;
    logic [31:0] probe_count_reg, probe_count_next;
    logic [31:0] drop_count_reg, drop_count_next;
    logic [31:0] sent_stamp_reg, sent_stamp_next;
    logic        stamp_valid_reg, stamp_valid_next;
    logic        done_flag_reg, done_flag_next;

    logic [15:0] id_base;
    logic [31:0] count_inc;
    logic        limit_hit;
    logic        adv;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            probe_limit_reg <= cfg_limit;
        end
    end

    // finish test on the advanced count
    assign count_inc = probe_count_reg + 32'd1;
    assign limit_hit = (probe_limit_reg != '0) && !count_inc[31]
                       && (count_inc >= {16'b0, probe_limit_reg});

    // event decode and next state
    always_comb
    begin
        outstanding_next = outstanding_reg;
        current_id_next  = current_id_reg;
        probe_count_next = probe_count_reg;
        drop_count_next  = drop_count_reg;
        sent_stamp_next  = sent_stamp_reg;
        stamp_valid_next = stamp_valid_reg;
        done_flag_next   = done_flag_reg;
        id_base          = current_id_reg;
        adv              = 1'b0;
        res.status       = rpt_pkg::ST_FINISHED;
        res.rtt          = '0;
        res.meas         = 1'b0;
        if (!done_flag_reg)
        begin
            case (rpt_pkg::op_t'(operation))
                rpt_pkg::OP_START:
                begin
                    id_base    = ip_id + rpt_pkg::ID_SEED_OFFSET;
                    adv        = 1'b1;
                    res.status = rpt_pkg::ST_STARTED;
                end
                rpt_pkg::OP_ISSUE:
                begin
                    outstanding_next = 1'b1;
                    res.status       = rpt_pkg::ST_ISSUED;
                end
                rpt_pkg::OP_PACKET:
                begin
                    if (outstanding_reg && (ip_id == current_id_reg))
                    begin
                        sent_stamp_next  = stamp_us;
                        stamp_valid_next = 1'b1;
                    end
                    res.status = rpt_pkg::ST_STAMP;
                end
                rpt_pkg::OP_RESPONSE:
                begin
                    if (!outstanding_reg)
                    begin
                        res.status = rpt_pkg::ST_UNKNOWN;
                    end
                    else
                    begin
                        outstanding_next = 1'b0;
                        if (stamp_valid_reg)
                        begin
                            res.rtt    = stamp_us - sent_stamp_reg;
                            res.meas   = 1'b1;
                            res.status = rpt_pkg::ST_MEASURED;
                        end
                        else
                        begin
                            res.status = rpt_pkg::ST_UNMATCHED;
                        end
                        adv = 1'b1;
                    end
                end
                rpt_pkg::OP_TIMEOUT:
                begin
                    outstanding_next = 1'b0;
                    drop_count_next  = drop_count_reg + 32'd1;
                    adv              = 1'b1;
                    res.status       = rpt_pkg::ST_TIMEOUT;
                end
                default:
                begin
                    // undefined event, no state change
                end
            endcase
        end
        // advance to the next probe
        if (adv)
        begin
            current_id_next  = id_base + 16'd1;
            probe_count_next = count_inc;
            stamp_valid_next = 1'b0;
            if (limit_hit)
            begin
                done_flag_next = 1'b1;
            end
        end
        res.probe_id    = current_id_next;
        res.probe_count = probe_count_next;
        res.drop_count  = drop_count_next;
        res.done        = done_flag_next;
    end

    // state update on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 1'b0;
            current_id_reg  <= '0;
            probe_count_reg <= rpt_pkg::COUNT_RESET;
            drop_count_reg  <= '0;
            sent_stamp_reg  <= '0;
            stamp_valid_reg <= 1'b0;
            done_flag_reg   <= 1'b0;
        end
        else if (fire)
        begin
            outstanding_reg <= outstanding_next;
            current_id_reg  <= current_id_next;
            probe_count_reg <= probe_count_next;
            drop_count_reg  <= drop_count_next;
            sent_stamp_reg  <= sent_stamp_next;
            stamp_valid_reg <= stamp_valid_next;
            done_flag_reg   <= done_flag_next;
        end
    end

    // finish is sticky
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_flag_reg |=> done_flag_reg)
        else $error("finish flag cleared");

    // a recorded stamp always belongs to an outstanding probe
    a_stamp_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        stamp_valid_reg |-> outstanding_reg)
        else $error("stamp recorded with no probe outstanding");

    // after finish the probe id no longer moves
    a_done_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done_flag_reg |=> $stable(current_id_reg))
        else $error("probe id changed after finish");

endmodule

FILE: hw/rtl/rpt_stats.sv
// ----------------------------------------------------------------------------
// rpt_stats
// RTT statistics: min, max, saturating sum, smoothed average and deviation,
// and the retransmit timeout derived from them.
// ----------------------------------------------------------------------------
module rpt_stats
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd,
    input  logic [31:0]        rtt,
    input  logic [31:0]        probes_done,
    input  logic [31:0]        drops,
    output logic [31:0]        rtt_min,
    output logic [31:0]        rtt_max,
    output logic signed [33:0] rtt_avg,
    output logic [31:0]        rtt_dev,
    output logic [47:0]        rtt_sum,
    output logic [31:0]        rto_us
);

    logic [31:0]        min_reg, min_next;
    logic [31:0]        max_reg, max_next;
    logic signed [33:0] avg_reg, avg_next;
    logic [31:0]        dev_reg, dev_next;
    logic [47:0]        sum_reg, sum_next;

    logic signed [37:0] avg_ext;
    logic signed [37:0] avg_acc;
    logic signed [34:0] err_pos;
    logic signed [34:0] err_neg;
    logic [34:0]        mag;
    logic [36:0]        dev_acc;
    logic [48:0]        sum_acc;
    logic signed [32:0] live;
    logic               first_rto;
    logic signed [35:0] rto_acc;

    // min, max and saturating sum
    always_comb
    begin
        min_next = (rtt < min_reg) ? rtt : min_reg;
        max_next = (rtt > max_reg) ? rtt : max_reg;
        sum_acc  = {1'b0, sum_reg} + {17'b0, rtt};
        sum_next = sum_acc[48] ? '1 : sum_acc[47:0];
    end

    // average: avg + floor((rtt - avg) / 8) == floor((rtt + 7 avg) / 8)
    always_comb
    begin
        avg_ext  = {{4{avg_reg[33]}}, avg_reg};
        avg_acc  = $signed({6'b0, rtt}) + (avg_ext <<< 3) - avg_ext;
        avg_next = avg_acc[36:3];
    end

    // deviation: dev + floor((|err| - dev) / 4) == floor((|err| + 3 dev) / 4)
    always_comb
    begin
        err_pos  = $signed({3'b0, rtt}) - $signed({avg_reg[33], avg_reg});
        err_neg  = $signed({avg_reg[33], avg_reg}) - $signed({3'b0, rtt});
        mag      = err_pos[34] ? err_neg : err_pos;
        dev_acc  = {2'b0, mag} + {5'b0, dev_reg} + {4'b0, dev_reg, 1'b0};
        dev_next = (|dev_acc[36:34]) ? '1 : dev_acc[33:2];
    end

    // statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
            avg_reg <= '0;
            dev_reg <= rpt_pkg::DEV_RESET;
            sum_reg <= '0;
        end
        else if (upd)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            avg_reg <= avg_next;
            dev_reg <= dev_next;
            sum_reg <= sum_next;
        end
    end

    // retransmit timeout, saturated to 32 bits
    always_comb
    begin
        live      = $signed({probes_done[31], probes_done}) - $signed({drops[31], drops});
        first_rto = live[32] || (live == '0);
        if (first_rto)
        begin
            rto_acc = $signed({3'b0, dev_reg, 1'b0});
        end
        else
        begin
            rto_acc = $signed({{2{avg_reg[33]}}, avg_reg}) + $signed({2'b0, dev_reg, 2'b0});
        end
        if (rto_acc[35])
        begin
            rto_us = '0;
        end
        else if (|rto_acc[34:32])
        begin
            rto_us = '1;
        end
        else
        begin
            rto_us = rto_acc[31:0];
        end
    end

    assign rtt_min = min_reg;
    assign rtt_max = max_reg;
    assign rtt_avg = avg_reg;
    assign rtt_dev = dev_reg;
    assign rtt_sum = sum_reg;

    // once a sample is in, min never exceeds max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (min_reg <= max_reg))
        else $error("rtt min above rtt max");

endmodule

FILE: hw/rtl/rtt_probe_tracker.sv
// ----------------------------------------------------------------------------
// rtt_probe_tracker
// Round-trip probe tracker with smoothed RTT statistics.
// ----------------------------------------------------------------------------
// Takes one event per clock while not stalled and returns one result per
// defined event; events with an undefined code are consumed and give no
// result. An accepted event sits in the input register, is decoded against
// the probe control state as it leaves there, and its result passes the
// control stage register into the output register. The control state (id,
// outstanding, counters) turns over once per event that leaves the input
// register, and the statistics (min, max, sum, average, deviation) update as
// a measured result enters the output register, so throughput is one event
// per cycle while the output is not stalled. The retransmit timeout comes
// from output-side registers. No reset sweep: events go in right after reset.
// ----------------------------------------------------------------------------
module rtt_probe_tracker
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_probe_limit,
    // event input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [15:0]        ip_id,
    input  logic [31:0]        stamp_us,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [15:0]        probe_id,
    output logic [31:0]        rto_us,
    output logic [31:0]        rtt_us,
    output logic [31:0]        rtt_min,
    output logic [31:0]        rtt_max,
    output logic signed [33:0] rtt_avg,
    output logic [31:0]        rtt_dev,
    output logic [47:0]        rtt_sum,
    output logic [31:0]        probes_done,
    output logic [31:0]        drops,
    output logic               finished
);

    logic                in_valid_reg;
    logic [2:0]          in_op_reg;
    logic [15:0]         in_ip_id_reg;
    logic [31:0]         in_stamp_reg;

    logic                s1_valid_reg;
    rpt_pkg::ctrl_res_t  s1_res_reg;
    rpt_pkg::ctrl_res_t  ctrl_res;

    logic                out_valid_reg;
    rpt_pkg::status_t    out_status_reg;
    logic [15:0]         out_id_reg;
    logic [31:0]         out_rtt_reg;
    logic [31:0]         out_probes_reg;
    logic [31:0]         out_drops_reg;
    logic                out_done_reg;

    logic                in_accept;
    logic                op_known;
    logic                move_out;
    logic                s1_free;
    logic                fire;

    // pipeline handshake
    assign cfg_ready = 1'b1;
    assign op_known  = (in_op_reg <= rpt_pkg::OP_TIMEOUT);
    assign move_out  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_free   = !s1_valid_reg || move_out;
    assign fire      = in_valid_reg && (s1_free || !op_known);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg    <= operation;
            in_ip_id_reg <= ip_id;
            in_stamp_reg <= stamp_us;
        end
    end

    // probe control stage
    rpt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_limit (cfg_probe_limit),
        .fire      (fire),
        .operation (in_op_reg),
        .ip_id     (in_ip_id_reg),
        .stamp_us  (in_stamp_reg),
        .res       (ctrl_res)
    );

    // control stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (fire && op_known)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (move_out)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && op_known)
        begin
            s1_res_reg <= ctrl_res;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= move_out || (out_valid_reg && out_stall);
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (move_out)
        begin
            out_status_reg <= s1_res_reg.status;
            out_id_reg     <= s1_res_reg.probe_id;
            out_rtt_reg    <= s1_res_reg.rtt;
            out_probes_reg <= s1_res_reg.probe_count;
            out_drops_reg  <= s1_res_reg.drop_count;
            out_done_reg   <= s1_res_reg.done;
        end
    end

    // statistics, updated as a measured result enters the output register
    rpt_stats u_stats
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (move_out && s1_res_reg.meas),
        .rtt         (s1_res_reg.rtt),
        .probes_done (out_probes_reg),
        .drops       (out_drops_reg),
        .rtt_min     (rtt_min),
        .rtt_max     (rtt_max),
        .rtt_avg     (rtt_avg),
        .rtt_dev     (rtt_dev),
        .rtt_sum     (rtt_sum),
        .rto_us      (rto_us)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign probe_id    = out_id_reg;
    assign rtt_us      = out_rtt_reg;
    assign probes_done = out_probes_reg;
    assign drops       = out_drops_reg;
    assign finished    = out_done_reg;

    // a decoded event waiting behind a stalled output is never dropped
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !move_out |=> s1_valid_reg)
        else $error("control stage result lost");

    // every defined event that leaves the input register produces a result
    a_known_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op_known |=> s1_valid_reg)
        else $error("defined event produced no result");

    // undefined events never reach the output side
    a_unknown_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !op_known && !s1_valid_reg |=> !s1_valid_reg)
        else $error("undefined event produced a result");

endmodule
